// File: rtl/core/psll_pkg.sv
// Package for the pooled sorted linked list: operation and status codes,
// request struct. No dependencies.
`timescale 1ns / 1ps
package psll_pkg;
  typedef enum logic [2:0] {
    KIND_INS_HEAD = 3'd0,
    KIND_INS_TAIL = 3'd1,
    KIND_INS_SORT = 3'd2,
    KIND_REM_HEAD = 3'd3,
    KIND_REM_TAIL = 3'd4,
    KIND_REM_VAL  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // classified request passed from front to back
  typedef struct packed {
    logic        is_ins;
    logic        is_rem;
    logic [2:0]  kind;
    logic [31:0] value;
  } req_t;
endpackage

// File: rtl/core/psll_front.sv
// Front end: takes input requests, classifies them and holds a two-entry queue.
// Depends on psll_pkg.
`timescale 1ns / 1ps
module psll_front
  import psll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] value_i,
  output logic        req_valid_o,
  input  logic        req_ready_i,
  output req_t        req_o
);
  req_t       q_mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  req_t       r;

  always_comb begin
    r.kind   = kind_i;
    r.value  = value_i;
    r.is_ins = (kind_i == KIND_INS_HEAD) || (kind_i == KIND_INS_TAIL) ||
               (kind_i == KIND_INS_SORT);
    r.is_rem = (kind_i == KIND_REM_HEAD) || (kind_i == KIND_REM_TAIL) ||
               (kind_i == KIND_REM_VAL);
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = q_mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/core/psll_back.sv
// Back end: walks the linked list held in register slots, one link per cycle,
// and writes back. Depends on psll_pkg.
`timescale 1ns / 1ps
module psll_back
  import psll_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] removed_value_o,
  output logic [2:0]  slot_o,
  output logic [3:0]  count_o
);
  localparam int unsigned SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CW = $clog2(POOL_SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_e;

  logic [31:0]   val_q  [POOL_SLOTS];
  logic [SW-1:0] link_q [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] used_q;
  logic [SW-1:0] head_q, tail_q, cur_q, prev_q, free_q;
  logic [CW-1:0] cnt_q, idx_q;
  logic          has_prev_q;
  req_t          req_q;
  state_e        state_q;
  logic          free_ok;
  logic [SW-1:0] free_idx;

  // lowest free slot: priority encoder over the used bits
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_ok  = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign req_ready_o = (state_q == S_IDLE) && !res_valid_o;

  // element count after removal of one element
  function automatic logic [CW-1:0] dec1(input logic [CW-1:0] c);
    dec1 = c - CW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      used_q          <= '0;
      head_q          <= '0;
      tail_q          <= '0;
      cnt_q           <= '0;
      res_valid_o     <= 1'b0;
      status_o        <= ST_OK;
      removed_value_o <= '0;
      slot_o          <= '0;
      count_o         <= '0;
      cur_q           <= '0;
      prev_q          <= '0;
      free_q          <= '0;
      idx_q           <= '0;
      has_prev_q      <= 1'b0;
      req_q           <= '0;
    end else begin
      if (res_valid_o && res_ready_i) res_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && req_ready_o) begin
            req_q      <= req_i;
            cur_q      <= head_q;
            prev_q     <= '0;
            has_prev_q <= 1'b0;
            idx_q      <= '0;
            free_q     <= free_idx;
            status_o        <= ST_OK;
            removed_value_o <= '0;
            slot_o          <= '0;
            if (req_i.is_ins && !free_ok) begin
              status_o <= ST_FULL;
              state_q  <= S_DONE;
            end else if (req_i.is_rem && cnt_q == '0) begin
              status_o <= ST_EMPTY;
              state_q  <= S_DONE;
            end else if (!req_i.is_ins && !req_i.is_rem) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_WALK;
            end
          end
        end
        S_WALK: begin
          // one link per cycle; each branch decides stop or advance
          case (req_q.kind)
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_SORT: begin
              if (req_q.kind == KIND_INS_SORT && idx_q != cnt_q &&
                  !($signed(val_q[cur_q]) > $signed(req_q.value))) begin
                has_prev_q <= 1'b1;
                prev_q     <= cur_q;
                cur_q      <= link_q[cur_q];
                idx_q      <= idx_q + CW'(1);
              end else begin
                val_q[free_q]  <= req_q.value;
                used_q[free_q] <= 1'b1;
                link_q[free_q] <= '0;
                slot_o         <= 3'(free_q);
                if (cnt_q == '0) begin
                  head_q <= free_q;
                  tail_q <= free_q;
                end else if (req_q.kind == KIND_INS_TAIL) begin
                  link_q[tail_q] <= free_q;
                  tail_q         <= free_q;
                end else if (req_q.kind == KIND_INS_HEAD || !has_prev_q) begin
                  link_q[free_q] <= head_q;
                  head_q         <= free_q;
                end else if (prev_q == tail_q) begin
                  link_q[prev_q] <= free_q;
                  tail_q         <= free_q;
                end else begin
                  link_q[free_q] <= link_q[prev_q];
                  link_q[prev_q] <= free_q;
                end
                cnt_q   <= cnt_q + CW'(1);
                state_q <= S_DONE;
              end
            end
            KIND_REM_HEAD: begin
              removed_value_o <= val_q[head_q];
              slot_o          <= 3'(head_q);
              used_q[head_q]  <= 1'b0;
              cnt_q           <= dec1(cnt_q);
              if (cnt_q == CW'(1)) begin
                head_q <= '0;
                tail_q <= '0;
              end else begin
                head_q <= link_q[head_q];
              end
              state_q <= S_DONE;
            end
            KIND_REM_TAIL: begin
              if (cnt_q > CW'(1) && idx_q + CW'(2) < cnt_q) begin
                cur_q <= link_q[cur_q];
                idx_q <= idx_q + CW'(1);
              end else begin
                removed_value_o <= val_q[tail_q];
                slot_o          <= 3'(tail_q);
                used_q[tail_q]  <= 1'b0;
                cnt_q           <= dec1(cnt_q);
                if (cnt_q == CW'(1)) begin
                  head_q <= '0;
                  tail_q <= '0;
                end else begin
                  tail_q <= cur_q;
                end
                state_q <= S_DONE;
              end
            end
            default: begin
              if (idx_q == cnt_q) begin
                status_o <= ST_NOT_FOUND;
                state_q  <= S_DONE;
              end else if (val_q[cur_q] != req_q.value) begin
                has_prev_q <= 1'b1;
                prev_q     <= cur_q;
                cur_q      <= link_q[cur_q];
                idx_q      <= idx_q + CW'(1);
              end else begin
                removed_value_o <= val_q[cur_q];
                slot_o          <= 3'(cur_q);
                used_q[cur_q]   <= 1'b0;
                cnt_q           <= dec1(cnt_q);
                if (!has_prev_q) head_q <= link_q[cur_q];
                else link_q[prev_q] <= link_q[cur_q];
                if (cur_q == tail_q && has_prev_q) tail_q <= prev_q;
                if (cnt_q == CW'(1)) begin
                  head_q <= '0;
                  tail_q <= '0;
                end
                state_q <= S_DONE;
              end
            end
          endcase
        end
        S_DONE: begin
          res_valid_o <= 1'b1;
          count_o     <= 4'(cnt_q);
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/pooled_sorted_linked_list_top.sv
// Full, empty and unused kinds skip the link walk; head/tail insert and head removal
// take a single walk step; sorted insert, tail removal and value removal take one
// walk step per list link walked.
// Throughput: one request at a time in the back end, set by the link walk.
// Reset (async, active low) empties the list; slot contents stay undefined.
// Depends on psll_pkg, psll_front, psll_back.
`timescale 1ns / 1ps
module pooled_sorted_linked_list_top
  import psll_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[31:0]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0] removed_value[33:2] slot[36:34] count[40:37]
);
  logic        req_valid, req_ready;
  req_t        req;
  logic [1:0]  status;
  logic [31:0] removed_value;
  logic [2:0]  slot;
  logic [3:0]  count;

  psll_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .kind_i     (s_axis_tuser),
    .value_i    (s_axis_tdata),
    .req_valid_o(req_valid),
    .req_ready_i(req_ready),
    .req_o      (req)
  );

  psll_back #(.POOL_SLOTS(POOL_SLOTS)) u_back (
    .clk_i, .rst_ni,
    .req_valid_i    (req_valid),
    .req_ready_o    (req_ready),
    .req_i          (req),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .status_o       (status),
    .removed_value_o(removed_value),
    .slot_o         (slot),
    .count_o        (count)
  );

  assign m_axis_tdata = {7'd0, count, slot, removed_value, status};
endmodule

// File: sim/tb_pooled_sorted_linked_list_top.sv
// Testbench for pooled_sorted_linked_list_top: directed table then random list
// operations, each result checked against a behavioral list model.
// Depends on psll_pkg and the RTL top.
`timescale 1ns / 1ps
module tb_pooled_sorted_linked_list_top;
  import psll_pkg::*;

  localparam int NSLOT = 8;
  localparam int NRAND = 830;

  // member order matches the result packing, count in the top bits
  typedef struct packed {
    logic [3:0]  count;
    logic [2:0]  slot;
    logic [31:0] removed;
    logic [1:0]  status;
  } list_res_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] value;
    bit          has_res;
    list_res_t   res;
  } stim_row_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [47:0] m_axis_tdata;

  pooled_sorted_linked_list_top #(.POOL_SLOTS(NSLOT)) dut (.*);

  always #5 clk_i = ~clk_i;

  // list model state
  logic [31:0] lst_val [NSLOT];
  logic [2:0]  lst_nxt [NSLOT];
  bit          lst_used [NSLOT];
  logic [2:0]  lst_head, lst_tail;
  int          lst_cnt;

  list_res_t   pending_q[$];
  int          fails = 0, n_res = 0, n_full = 0, n_empty = 0, n_nf = 0;
  int          send_idle = 35, recv_idle = 83;

  function automatic void release_slot(int s);
    lst_used[s] = 0;
    if (lst_cnt > 0) lst_cnt--;
    if (lst_cnt == 0) begin
      lst_head = 0;
      lst_tail = 0;
    end
  endfunction

  function automatic list_res_t apply_op(logic [2:0] kind, logic [31:0] v);
    list_res_t r;
    int f, prv, cur, i;
    bit has_prv;
    r = '0;
    if (kind <= KIND_INS_SORT) begin
      f = -1;
      for (i = 0; i < NSLOT; i++)
        if (!lst_used[i] && f < 0) f = i;
      if (f < 0) r.status = ST_FULL;
      else begin
        lst_val[f] = v; lst_used[f] = 1; lst_nxt[f] = 0; r.slot = f;
        has_prv = 0; prv = 0;
        if (kind == KIND_INS_TAIL && lst_cnt > 0) begin
          has_prv = 1; prv = lst_tail;
        end else if (kind == KIND_INS_SORT) begin
          cur = lst_head;
          for (i = 0; i < lst_cnt; i++) begin
            if ($signed(lst_val[cur]) > $signed(v)) break;
            has_prv = 1; prv = cur; cur = lst_nxt[cur];
          end
        end
        if (lst_cnt == 0) begin
          lst_head = f; lst_tail = f;
        end else if (!has_prv) begin
          lst_nxt[f] = lst_head; lst_head = f;
        end else if (prv == lst_tail) begin
          lst_nxt[prv] = f; lst_tail = f;
        end else begin
          lst_nxt[f] = lst_nxt[prv]; lst_nxt[prv] = f;
        end
        lst_cnt++;
      end
    end else if (kind <= KIND_REM_VAL) begin
      if (lst_cnt == 0) r.status = ST_EMPTY;
      else if (kind == KIND_REM_HEAD) begin
        f = lst_head; r.removed = lst_val[f]; r.slot = f;
        lst_head = lst_nxt[f];
        release_slot(f);
      end else if (kind == KIND_REM_TAIL) begin
        f = lst_tail; r.removed = lst_val[f]; r.slot = f;
        if (lst_cnt > 1) begin
          cur = lst_head;
          for (i = 0; i + 2 < lst_cnt; i++) cur = lst_nxt[cur];
          lst_tail = cur;
        end
        release_slot(f);
      end else begin
        has_prv = 0; prv = 0; cur = lst_head;
        for (i = 0; i < lst_cnt; i++) begin
          if (lst_val[cur] == v) break;
          has_prv = 1; prv = cur; cur = lst_nxt[cur];
        end
        if (i == lst_cnt) r.status = ST_NOT_FOUND;
        else begin
          r.removed = lst_val[cur]; r.slot = cur;
          if (!has_prv) lst_head = lst_nxt[cur];
          else lst_nxt[prv] = lst_nxt[cur];
          if (cur == lst_tail && has_prv) lst_tail = prv;
          release_slot(cur);
        end
      end
    end
    r.count = lst_cnt;
    return r;
  endfunction

  // valid stays up between back-to-back requests; dropped only while idling
  task automatic send_op(logic [2:0] kind, logic [31:0] v, bit has_res, list_res_t res);
    list_res_t p;
    bit idle;
    idle = (send_idle > 0) && ($urandom_range(99) < send_idle);
    if (idle) s_axis_tvalid <= 0;
    while (idle) begin
      @(posedge clk_i);
      idle = ($urandom_range(99) < send_idle);
    end
    p = apply_op(kind, v);
    if (has_res && p !== res)
      $error("table row disagrees with list model: exp %h got %h", res, p);
    pending_q.push_back(has_res ? res : p);
    s_axis_tvalid <= 1;
    s_axis_tdata <= v;
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // result side: random stall, then compare with oldest expectation
  always @(posedge clk_i) begin
    list_res_t got, ex;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[40:0];
        n_res++;
        if (pending_q.size() == 0) begin
          $error("result with no request pending: %h", got);
          fails++;
        end else begin
          ex = pending_q.pop_front();
          case (ex.status)
            ST_FULL: n_full++;
            ST_EMPTY: n_empty++;
            ST_NOT_FOUND: n_nf++;
            default: ;
          endcase
          if (got.status !== ex.status) begin
            $error("status exp %0d got %0d", ex.status, got.status); fails++;
          end
          if (got.removed !== ex.removed) begin
            $error("removed_value exp %h got %h", ex.removed, got.removed); fails++;
          end
          if (got.slot !== ex.slot) begin
            $error("slot exp %0d got %0d", ex.slot, got.slot); fails++;
          end
          if (got.count !== ex.count) begin
            $error("count exp %0d got %0d", ex.count, got.count); fails++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic list_res_t mk(logic [1:0] st, logic [31:0] rv, int sl, int c);
    list_res_t r;
    r.status = st; r.removed = rv; r.slot = sl; r.count = c;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $urandom_range(12) - 6;  // small range so matches and ties happen
    endcase
  endfunction

  initial begin
    stim_row_t tbl[$];
    logic [31:0] vals[$];
    logic [2:0] k;
    int idx;
    for (int i = 0; i < NSLOT; i++) begin
      lst_val[i] = 0; lst_nxt[i] = 0; lst_used[i] = 0;
    end
    lst_head = 0; lst_tail = 0; lst_cnt = 0;

    tbl.push_back('{KIND_REM_HEAD, 32'h0, 1, mk(ST_EMPTY, 0, 0, 0)});
    tbl.push_back('{KIND_REM_TAIL, 32'h0, 1, mk(ST_EMPTY, 0, 0, 0)});
    tbl.push_back('{KIND_REM_VAL, 32'h5, 1, mk(ST_EMPTY, 0, 0, 0)});
    tbl.push_back('{KIND_INS_HEAD, 32'h8000_0000, 1, mk(ST_OK, 0, 0, 1)});
    tbl.push_back('{KIND_INS_TAIL, 32'h7fff_ffff, 1, mk(ST_OK, 0, 1, 2)});
    tbl.push_back('{KIND_INS_SORT, 32'h0000_0003, 0, '0});
    tbl.push_back('{KIND_INS_SORT, 32'h0000_0003, 0, '0});  // tie goes after
    tbl.push_back('{KIND_INS_SORT, 32'hffff_fffe, 0, '0});
    tbl.push_back('{KIND_INS_SORT, 32'hffff_ffff, 0, '0});
    tbl.push_back('{KIND_INS_HEAD, 32'h5555_5555, 0, '0});
    tbl.push_back('{KIND_INS_TAIL, 32'haaaa_aaaa, 1, mk(ST_OK, 0, 7, 8)});
    tbl.push_back('{KIND_INS_SORT, 32'h1, 1, mk(ST_FULL, 0, 0, 8)});
    tbl.push_back('{KIND_REM_VAL, 32'h1234, 1, mk(ST_NOT_FOUND, 0, 0, 8)});
    tbl.push_back('{KIND_REM_VAL, 32'h0000_0003, 0, '0});
    tbl.push_back('{KIND_REM_TAIL, 32'h0, 0, '0});
    tbl.push_back('{KIND_REM_HEAD, 32'h0, 0, '0});
    tbl.push_back('{KIND_INS_SORT, 32'h0000_0002, 0, '0});
    tbl.push_back('{3'd6, 32'hffff_ffff, 0, '0});
    tbl.push_back('{3'd7, 32'h0, 0, '0});
    tbl.push_back('{KIND_REM_VAL, 32'h7fff_ffff, 0, '0});
    for (int i = 0; i < 6; i++) tbl.push_back('{KIND_REM_TAIL, 32'h0, 0, '0});
    tbl.push_back('{KIND_INS_SORT, 32'h9, 1, mk(ST_OK, 0, 0, 1)});
    tbl.push_back('{KIND_REM_VAL, 32'h9, 1, mk(ST_OK, 32'h9, 0, 0)});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    foreach (tbl[i]) send_op(tbl[i].kind, tbl[i].value, tbl[i].has_res, tbl[i].res);

    for (int n = 0; n < NRAND; n++) begin
      if (n == NRAND / 3) begin send_idle = 83; recv_idle = 35; end
      if (n == 2 * NRAND / 3) begin send_idle = 0; recv_idle = 0; end
      // bias toward inserts when short, removals when long, so full/empty both recur
      if ($urandom_range(19) == 0) k = $urandom_range(7);
      else if ($urandom_range(NSLOT) >= lst_cnt) k = $urandom_range(2);
      else k = $urandom_range(5, 3);
      if (k == KIND_REM_VAL && lst_cnt > 0 && $urandom_range(3) != 0) begin
        vals.delete();
        for (int i = 0; i < NSLOT; i++) if (lst_used[i]) vals.push_back(lst_val[i]);
        idx = $urandom_range(vals.size() - 1);
        send_op(k, vals[idx], 0, '0);
      end else begin
        send_op(k, pick_value(), 0, '0);
      end
    end
    s_axis_tvalid <= 0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Ran %0d list operations, %0d results: %0d full, %0d empty, %0d not found.",
             tbl.size() + NRAND, n_res, n_full, n_empty, n_nf);
    if (fails == 0 && pending_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
